[rtl/ecm_pkg.sv]
// ----------------------------------------------------------------------------
// ecm_pkg
// shared types, constants and helpers of the ease curve multiplier
// ----------------------------------------------------------------------------
package ecm_pkg;

    localparam int unsigned RES_W     = 17;
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned REM_W     = 33;

    localparam logic [RES_W-1:0] T_ONE = 17'h10000;

    // register indexes of the configuration port
    localparam logic [2:0] REG_IN_START  = 3'd0;
    localparam logic [2:0] REG_IN_END    = 3'd1;
    localparam logic [2:0] REG_OUT_START = 3'd2;
    localparam logic [2:0] REG_OUT_END   = 3'd3;
    localparam logic [2:0] REG_IN_CURVE  = 3'd4;
    localparam logic [2:0] REG_OUT_CURVE = 3'd5;
    localparam logic [2:0] REG_ENABLES   = 3'd6;

    // 1/255 scaled by 2^24, rounded down
    localparam logic [16:0] RECIP_255 = 17'h10101;

    typedef enum logic [1:0] {
        MODE_ONE,
        MODE_BEZ,
        MODE_XF
    } ecm_mode_t;

    typedef struct packed {
        ecm_mode_t        mode;
        logic             sel_in;
        logic             fixed;
        logic [RES_W-1:0] tfix;
    } ecm_side_t;

    function automatic logic [7:0] ctl_byte(input logic [31:0] curve, input logic [1:0] k);
        logic [7:0] b;
        begin
            unique case (k)
                2'd0:    b = curve[7:0];
                2'd1:    b = curve[15:8];
                2'd2:    b = curve[23:16];
                default: b = curve[31:24];
            endcase
            return b;
        end
    endfunction

endpackage

[rtl/ease_curve_multiplier_top.sv]
// ----------------------------------------------------------------------------
// ease_curve_multiplier_top
// fade multiplier from a clock sample through cubic bezier ease curves
// ----------------------------------------------------------------------------
// One clock sample enters per cycle and one multiplier leaves per cycle while
// the output is not stalled. The middle of the pipeline is the curve parameter
// divider, which resolves one quotient bit per stage over 16 stages; three
// stages before it pick the active segment and clamp the ratio, seven after
// it evaluate the bezier polynomial and divide by 255. All stages hold
// together while a finished result sits stalled in the output register, so
// in_stall follows out_stall whenever out_valid is high. Configuration must
// be written through cfg_write_en / cfg_index / cfg_data only while no
// transaction is in flight; the block itself does not enforce this.
module ease_curve_multiplier_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] current_clock,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [16:0]        multiplier
);

    localparam int unsigned RW = ecm_pkg::RES_W;
    localparam int unsigned QW = ecm_pkg::DIV_STEPS;
    localparam int unsigned MW = ecm_pkg::REM_W;

    // configuration registers
    logic signed [31:0] in_start_reg, in_end_reg, out_start_reg, out_end_reg;
    logic [31:0]        in_curve_reg, out_curve_reg;
    logic [1:0]         enables_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_start_reg  <= '0;
            in_end_reg    <= '0;
            out_start_reg <= '0;
            out_end_reg   <= '0;
            in_curve_reg  <= 32'hFFFF0000;
            out_curve_reg <= 32'h0000FFFF;
            enables_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                ecm_pkg::REG_IN_START:  in_start_reg  <= cfg_data;
                ecm_pkg::REG_IN_END:    in_end_reg    <= cfg_data;
                ecm_pkg::REG_OUT_START: out_start_reg <= cfg_data;
                ecm_pkg::REG_OUT_END:   out_end_reg   <= cfg_data;
                ecm_pkg::REG_IN_CURVE:  in_curve_reg  <= cfg_data;
                ecm_pkg::REG_OUT_CURVE: out_curve_reg <= cfg_data;
                ecm_pkg::REG_ENABLES:   enables_reg   <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves unless the output holds a stalled transaction
    logic adv;
    logic out_valid_reg;
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // ---- stage 1: segment select and raw differences ----
    ecm_pkg::ecm_mode_t s1_mode;
    logic               s1_sel;
    logic signed [31:0] op_s, op_e;
    logic               en_in, en_out, both;
    logic signed [32:0] n1_next, d1_next;

    assign en_in  = enables_reg[0];
    assign en_out = enables_reg[1];
    assign both   = en_in && en_out && (in_start_reg >= out_start_reg);

    always_comb
    begin
        s1_mode = ecm_pkg::MODE_ONE;
        s1_sel  = 1'b1;
        op_s    = in_start_reg;
        op_e    = in_end_reg;
        if (both)
        begin
            priority if (current_clock <= out_end_reg)
            begin
                s1_mode = ecm_pkg::MODE_BEZ;
                s1_sel  = 1'b0;
                op_s    = out_start_reg;
                op_e    = out_end_reg;
            end
            else if (current_clock <= in_start_reg)
            begin
                // crossfade across the gap
                s1_mode = ecm_pkg::MODE_XF;
                op_s    = out_end_reg;
                op_e    = in_start_reg;
            end
            else if (current_clock <= in_end_reg)
            begin
                s1_mode = ecm_pkg::MODE_BEZ;
            end
            else
            begin
                s1_mode = ecm_pkg::MODE_ONE;
            end
        end
        else
        begin
            // ease-in overrides ease-out
            priority if (en_in && current_clock <= in_end_reg)
            begin
                s1_mode = ecm_pkg::MODE_BEZ;
            end
            else if (en_out && current_clock >= out_start_reg)
            begin
                s1_mode = ecm_pkg::MODE_BEZ;
                s1_sel  = 1'b0;
                op_s    = out_start_reg;
                op_e    = out_end_reg;
            end
            else
            begin
                s1_mode = ecm_pkg::MODE_ONE;
            end
        end
    end

    assign n1_next = {current_clock[31], current_clock} - {op_s[31], op_s};
    assign d1_next = {op_e[31], op_e} - {op_s[31], op_s};

    logic               s1_valid_reg;
    ecm_pkg::ecm_side_t s1_side_reg;
    logic signed [32:0] s1_n_reg, s1_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg.mode   <= s1_mode;
            s1_side_reg.sel_in <= s1_sel;
            s1_side_reg.fixed  <= 1'b0;
            s1_side_reg.tfix   <= '0;
            s1_n_reg           <= n1_next;
            s1_d_reg           <= d1_next;
        end
    end

    // ---- stage 2: zero span and sign normalization ----
    ecm_pkg::ecm_side_t s2_side_next;
    logic signed [33:0] n2_ext, d2_ext, n2_next, d2_next;

    assign n2_ext  = {s1_n_reg[32], s1_n_reg};
    assign d2_ext  = {s1_d_reg[32], s1_d_reg};
    assign n2_next = s1_d_reg[32] ? -n2_ext : n2_ext;
    assign d2_next = s1_d_reg[32] ? -d2_ext : d2_ext;

    always_comb
    begin
        s2_side_next       = s1_side_reg;
        s2_side_next.fixed = (s1_d_reg == '0);
        s2_side_next.tfix  = s1_n_reg[32] ? '0 : ecm_pkg::T_ONE;
    end

    logic               s2_valid_reg;
    ecm_pkg::ecm_side_t s2_side_reg;
    logic signed [33:0] s2_n_reg, s2_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s2_side_next;
            s2_n_reg    <= n2_next;
            s2_d_reg    <= d2_next;
        end
    end

    // ---- stage 3: clamp to 0..1 ----
    ecm_pkg::ecm_side_t s3_side_next;

    always_comb
    begin
        s3_side_next = s2_side_reg;
        if (!s2_side_reg.fixed)
        begin
            priority if (s2_n_reg <= 34'sd0)
            begin
                s3_side_next.fixed = 1'b1;
                s3_side_next.tfix  = '0;
            end
            else if (s2_n_reg >= s2_d_reg)
            begin
                s3_side_next.fixed = 1'b1;
                s3_side_next.tfix  = ecm_pkg::T_ONE;
            end
            else
            begin
                s3_side_next.fixed = 1'b0;
            end
        end
    end

    logic               s3_valid_reg;
    ecm_pkg::ecm_side_t s3_side_reg;
    logic [MW-1:0]      s3_rem_reg, s3_den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_side_reg <= s3_side_next;
            s3_rem_reg  <= s2_n_reg[MW-1:0];
            s3_den_reg  <= s2_d_reg[MW-1:0];
        end
    end

    // ---- stages 4..19: ratio divider ----
    logic               dv_valid;
    ecm_pkg::ecm_side_t dv_side;
    logic [QW-1:0]      dv_quo;

    ecm_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .in_side   (s3_side_reg),
        .in_rem    (s3_rem_reg),
        .in_den    (s3_den_reg),
        .out_valid (dv_valid),
        .out_side  (dv_side),
        .out_quo   (dv_quo)
    );

    // ---- stage A: squares, cross term, crossfade ----
    logic [RW-1:0] ta, ua;
    logic [7:0]    xo_b3, xi_b0;
    assign ta    = dv_side.fixed ? dv_side.tfix : {1'b0, dv_quo};
    assign ua    = ecm_pkg::T_ONE - ta;
    assign xo_b3 = ecm_pkg::ctl_byte(out_curve_reg, 2'd3);
    assign xi_b0 = ecm_pkg::ctl_byte(in_curve_reg, 2'd0);

    logic               sa_valid_reg;
    ecm_pkg::ecm_side_t sa_side_reg;
    logic [32:0]        sa_uu_reg, sa_tt_reg;
    logic [RW-1:0]      sa_u_reg, sa_t_reg;
    logic [23:0]        sa_xf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sa_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_side_reg <= dv_side;
            sa_uu_reg   <= 33'(ua * ua);
            sa_tt_reg   <= 33'(ta * ta);
            sa_u_reg    <= ua;
            sa_t_reg    <= ta;
            sa_xf_reg   <= 24'(ua * xo_b3) + 24'(ta * xi_b0);
        end
    end

    // ---- stage B: cubic basis terms ----
    logic               sb_valid_reg;
    ecm_pkg::ecm_side_t sb_side_reg;
    logic [48:0]        sb_w0_reg, sb_w1_reg, sb_w2_reg, sb_w3_reg;
    logic [23:0]        sb_xf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sb_valid_reg <= sa_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sb_side_reg <= sa_side_reg;
            sb_w0_reg   <= 49'(sa_uu_reg * sa_u_reg);
            sb_w1_reg   <= 49'(sa_uu_reg * sa_t_reg);
            sb_w2_reg   <= 49'(sa_tt_reg * sa_u_reg);
            sb_w3_reg   <= 49'(sa_tt_reg * sa_t_reg);
            sb_xf_reg   <= sa_xf_reg;
        end
    end

    // ---- stage C: weight by control bytes ----
    logic [31:0] crv;
    logic [9:0]  c0, c1, c2, c3;
    assign crv = sb_side_reg.sel_in ? in_curve_reg : out_curve_reg;
    assign c0  = {2'b00, ecm_pkg::ctl_byte(crv, 2'd0)};
    assign c1  = 10'(3 * ecm_pkg::ctl_byte(crv, 2'd1));
    assign c2  = 10'(3 * ecm_pkg::ctl_byte(crv, 2'd2));
    assign c3  = {2'b00, ecm_pkg::ctl_byte(crv, 2'd3)};

    logic               sc_valid_reg;
    ecm_pkg::ecm_side_t sc_side_reg;
    logic [58:0]        sc_p0_reg, sc_p1_reg, sc_p2_reg, sc_p3_reg;
    logic [23:0]        sc_xf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sc_valid_reg <= sb_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_side_reg <= sb_side_reg;
            sc_p0_reg   <= 59'(sb_w0_reg * c0);
            sc_p1_reg   <= 59'(sb_w1_reg * c1);
            sc_p2_reg   <= 59'(sb_w2_reg * c2);
            sc_p3_reg   <= 59'(sb_w3_reg * c3);
            sc_xf_reg   <= sb_xf_reg;
        end
    end

    // ---- stage D: pairwise sums ----
    logic               sd_valid_reg;
    ecm_pkg::ecm_side_t sd_side_reg;
    logic [59:0]        sd_s01_reg, sd_s23_reg;
    logic [23:0]        sd_xf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sd_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sd_valid_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_side_reg <= sc_side_reg;
            sd_s01_reg  <= {1'b0, sc_p0_reg} + {1'b0, sc_p1_reg};
            sd_s23_reg  <= {1'b0, sc_p2_reg} + {1'b0, sc_p3_reg};
            sd_xf_reg   <= sc_xf_reg;
        end
    end

    // ---- stage E: final sum, scale down to the dividend ----
    logic [60:0] sum_e;
    assign sum_e = {1'b0, sd_s01_reg} + {1'b0, sd_s23_reg};

    logic               se_valid_reg;
    ecm_pkg::ecm_side_t se_side_reg;
    logic [23:0]        se_x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            se_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            se_valid_reg <= sd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            se_side_reg <= sd_side_reg;
            se_x_reg    <= (sd_side_reg.mode == ecm_pkg::MODE_XF) ? sd_xf_reg
                                                                 : sum_e[55:32];
        end
    end

    // ---- stage F: divide by 255 via reciprocal, may be one low ----
    logic [40:0] qprod;
    assign qprod = se_x_reg * ecm_pkg::RECIP_255;

    logic               sf_valid_reg;
    ecm_pkg::ecm_side_t sf_side_reg;
    logic [23:0]        sf_x_reg;
    logic [RW-1:0]      sf_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sf_valid_reg <= se_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sf_side_reg <= se_side_reg;
            sf_x_reg    <= se_x_reg;
            sf_q_reg    <= qprod[40:24];
        end
    end

    // ---- stage G: quotient correction, output register ----
    logic [24:0]   rem_g;
    logic [RW-1:0] res_g;
    assign rem_g = {1'b0, sf_x_reg} - (25'(sf_q_reg) * 25'd255);
    assign res_g = (sf_side_reg.mode == ecm_pkg::MODE_ONE) ? ecm_pkg::T_ONE
                 : (rem_g >= 25'd255) ? RW'(sf_q_reg + 1'b1) : sf_q_reg;

    logic [RW-1:0] multiplier_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= sf_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            multiplier_reg <= res_g;
        end
    end

    assign out_valid  = out_valid_reg;
    assign multiplier = multiplier_reg;

endmodule

[rtl/ecm_div_pipe.sv]
// ----------------------------------------------------------------------------
// ecm_div_pipe
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ecm_div_pipe
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        adv,
    input  logic                        in_valid,
    input  ecm_pkg::ecm_side_t          in_side,
    input  logic [ecm_pkg::REM_W-1:0]   in_rem,
    input  logic [ecm_pkg::REM_W-1:0]   in_den,
    output logic                        out_valid,
    output ecm_pkg::ecm_side_t          out_side,
    output logic [ecm_pkg::DIV_STEPS-1:0] out_quo
);

    localparam int unsigned N = ecm_pkg::DIV_STEPS;
    localparam int unsigned W = ecm_pkg::REM_W;

    logic               valid_reg [N];
    ecm_pkg::ecm_side_t side_reg  [N];
    logic [W-1:0]       rem_reg   [N];
    logic [W-1:0]       den_reg   [N];
    logic [N-1:0]       quo_reg   [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_step
            logic               valid_prev;
            ecm_pkg::ecm_side_t side_prev;
            logic [W-1:0]       rem_prev;
            logic [W-1:0]       den_prev;
            logic [N-1:0]       quo_prev;
            logic [W:0]         rem_dbl;
            logic               ge;
            logic [W-1:0]       rem_next;

            if (k == 0) begin : g_first
                assign valid_prev = in_valid;
                assign side_prev  = in_side;
                assign rem_prev   = in_rem;
                assign den_prev   = in_den;
                assign quo_prev   = '0;
            end
            else begin : g_rest
                assign valid_prev = valid_reg[k-1];
                assign side_prev  = side_reg[k-1];
                assign rem_prev   = rem_reg[k-1];
                assign den_prev   = den_reg[k-1];
                assign quo_prev   = quo_reg[k-1];
            end

            // shift remainder, subtract divisor when it fits
            assign rem_dbl  = {rem_prev, 1'b0};
            assign ge       = (rem_dbl >= {1'b0, den_prev});
            assign rem_next = ge ? W'(rem_dbl - {1'b0, den_prev}) : rem_dbl[W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (adv)
                begin
                    valid_reg[k] <= valid_prev;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    side_reg[k] <= side_prev;
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= den_prev;
                    quo_reg[k]  <= {quo_prev[N-2:0], ge};
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign out_quo   = quo_reg[N-1];

endmodule

[rtl/ecm_checker.sv]
// ----------------------------------------------------------------------------
// ecm_checker
// port-level checks of the ease curve multiplier
// ----------------------------------------------------------------------------
module ecm_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [16:0] multiplier
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(multiplier))
        else $error("stalled result changed");

    // multiplier never exceeds 1.0
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> multiplier <= 17'h10000)
        else $error("multiplier above one");

    // input is held back only by a stalled result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

endmodule

bind ease_curve_multiplier_top ecm_checker u_ecm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .multiplier (multiplier)
);
